FILE: hw/rtl/shared_pool_multi_channel_packet_queue_unit_assert.svh
// assertion helpers for the packet queue unit
`ifndef SHARED_POOL_MULTI_CHANNEL_PACKET_QUEUE_UNIT_ASSERT_SVH
`define SHARED_POOL_MULTI_CHANNEL_PACKET_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define SPMQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmq same-cycle check failed");

// next-cycle implication
`define SPMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmq next-cycle check failed");

`endif

FILE: hw/rtl/spmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spmq_pkg;

   localparam int PTR_W  = 6;
   localparam int CNT_W  = 6;
   localparam int TOT_W  = 21;
   localparam int HND_W  = 16;
   localparam int SIZE_W = 20;
   localparam int CHN_W  = 4;

   localparam logic [PTR_W-1:0] NIL = 6'h3F;
   localparam logic [TOT_W:0] TOTAL_MAX = 22'd2097151;

   localparam logic [1:0] ACT_PUSH_TAIL = 2'd0;
   localparam logic [1:0] ACT_PUSH_HEAD = 2'd1;
   localparam logic [1:0] ACT_POP       = 2'd2;
   localparam logic [1:0] ACT_CLEAR     = 2'd3;

   localparam logic KIND_STATUS   = 1'b0;
   localparam logic KIND_RELEASED = 1'b1;

   localparam int LM_RST_NIL   = 0;
   localparam int LM_RST_CHAIN = 1;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      logic [PTR_W-1:0] data;
   } lnk_wr_type;

   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
      logic [CNT_W-1:0] count;
   } chan_rec_type;

   typedef struct packed {
      logic [HND_W-1:0]  handle;
      logic [SIZE_W-1:0] size;
      logic [CHN_W-1:0]  chan;
   } blk_type;

   typedef struct packed {
      logic [TOT_W-1:0]  total;
      logic [CNT_W-1:0]  count;
      logic [CHN_W-1:0]  chan;
      logic [SIZE_W-1:0] size;
      logic [HND_W-1:0]  handle;
      logic              ok;
      logic              kind;
      logic              last;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hw/rtl/spmq_lmem.sv
`timescale 1ns / 1ps
`default_nettype none
// link memory: one write, one registered read, per-entry valid bits
module spmq_lmem #(
   parameter int NUM_BLOCKS = 32,
   parameter int RST_MODE   = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire spmq_pkg::lnk_wr_type        wr,
   input  wire logic [spmq_pkg::PTR_W-1:0]  rd_addr,
   output logic      [spmq_pkg::PTR_W-1:0]  rd_data
);

   localparam int BW = $clog2(NUM_BLOCKS);

   logic [spmq_pkg::PTR_W-1:0] mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]      vld_ff;
   logic [spmq_pkg::PTR_W-1:0] rd_data_ff;
   logic [spmq_pkg::PTR_W-1:0] rst_val;
   logic [BW-1:0]              ri;

   assign ri = rd_addr[BW-1:0];

   // unwritten entries read as their power-on link
   always_comb begin
      if (RST_MODE == spmq_pkg::LM_RST_CHAIN && (int'(ri) + 1 < NUM_BLOCKS)) begin
         rst_val = spmq_pkg::PTR_W'(ri) + spmq_pkg::PTR_W'(1);
      end else begin
         rst_val = spmq_pkg::NIL;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[BW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr[BW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= vld_ff[ri] ? mem[ri] : rst_val;
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/shared_pool_multi_channel_packet_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "shared_pool_multi_channel_packet_queue_unit_assert.svh"
// Packet descriptor queue over a shared pool of NUM_BLOCKS blocks, NUM_CHANNELS queues.
// req channel: one word per operation, tuser = action (push tail, push head, pop, clear).
// rsp channel: zero or more released words (tuser = 1), then one status word with tlast.
// csr port: csr_wr_en writes the tail-push byte capacity (32768 after reset).
// One word is worked on at a time; req_tready is high only while idle.
// Steps from accept to a valid word:
//   out-of-range channel: straight to status
//   push head and push tail (queue record read, list read, block write, link update)
//   pop (block read, unlink, queue record update)
//   clear and eviction: one released word per released packet, then the clear status
//   or the push after the last eviction
// A new word can be taken in the cycle after the status word is taken.
// The walk is a sequencer over link, block and queue-record memories, each with one
// write and one registered read per cycle.
// rsp stall: the sequencer waits on the held output word and resumes when it is taken.
// Reset (synchronous): all queues empty, all blocks free, byte total zero.
module shared_pool_multi_channel_packet_queue_unit #(
   parameter int NUM_BLOCKS   = 32,
   parameter int NUM_CHANNELS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // channel[3:0], packet_handle[19:4], packet_size[39:20], auto_drop[40], zero pad
   input  wire logic [47:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // ok[0], out_handle[16:1], out_size[36:17], out_channel[40:37],
   // channel_count[46:41], total_bytes_now[67:47], zero pad
   output logic [71:0]      rsp_tdata,
   // kind[0]
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [20:0] csr_wr_data
);

   localparam int BW = $clog2(NUM_BLOCKS);
   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PW = spmq_pkg::PTR_W;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_CHECK, S_CLR, S_REL_RD, S_REL_LNK, S_REL_FIN,
      S_PL_RD, S_PL_A, S_PL_B, S_OUT
   } state_type;

   state_type                    state_ff, ret_ff;
   logic [1:0]                   act_ff;
   logic [spmq_pkg::CHN_W-1:0]   ch_ff;
   logic [spmq_pkg::HND_W-1:0]   h_ff;
   logic [spmq_pkg::SIZE_W-1:0]  s_ff;
   logic                         drop_ff;
   logic [spmq_pkg::TOT_W-1:0]   cap_ff, total_ff;
   logic [PW-1:0]                dhead_ff, dtail_ff, fhead_ff, b_ff, chead_ff;
   logic [spmq_pkg::CNT_W-1:0]   cnt_ff;
   spmq_pkg::rsp_type            rsp_ff;
   logic                         rsp_valid_ff;

   spmq_pkg::blk_type            blk_mem [NUM_BLOCKS];
   spmq_pkg::blk_type            blk_rd_ff;
   logic [PW-1:0]                cnext_mem [NUM_BLOCKS];
   logic [PW-1:0]                cprev_mem [NUM_BLOCKS];
   logic [PW-1:0]                cnext_rd_ff, cprev_rd_ff;
   spmq_pkg::chan_rec_type       ch_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]      chv_ff;
   spmq_pkg::chan_rec_type       ch_rd_ff;

   spmq_pkg::lnk_wr_type         tn_wr, tp_wr, cn_wr, cp_wr;
   logic [PW-1:0]                tn_rd, tp_rd;
   logic                         blk_we, ch_we;
   spmq_pkg::chan_rec_type       ch_wdata, rel_rec, pl_rec;
   logic [spmq_pkg::CHN_W-1:0]   ch_raddr, ch_waddr;
   logic [8:0]                   ch_ra_ext, ch_wa_ext, req_ch_ext;
   logic [BW-1:0]                bi;
   logic [spmq_pkg::TOT_W:0]     sum_ext;
   logic                         over_cap, over_max, ec_is_ch, req_oor;

   function automatic spmq_pkg::rsp_type mk_rsp(
      input logic                        kind,
      input logic                        ok,
      input logic [spmq_pkg::HND_W-1:0]  hnd,
      input logic [spmq_pkg::SIZE_W-1:0] sz,
      input logic [spmq_pkg::CHN_W-1:0]  chn,
      input logic [spmq_pkg::CNT_W-1:0]  cnt,
      input logic [spmq_pkg::TOT_W-1:0]  tot,
      input logic                        last
   );
      spmq_pkg::rsp_type r;
      r.kind   = kind;
      r.ok     = ok;
      r.handle = hnd;
      r.size   = sz;
      r.chan   = chn;
      r.count  = cnt;
      r.total  = tot;
      r.last   = last;
      return r;
   endfunction

   assign bi         = b_ff[BW-1:0];
   assign ch_ra_ext  = 9'(ch_raddr);
   assign ch_wa_ext  = 9'(ch_waddr);
   assign req_ch_ext = 9'(req_tdata[3:0]);
   assign req_oor    = req_ch_ext >= 9'(NUM_CHANNELS);
   assign sum_ext    = {1'b0, total_ff} + (spmq_pkg::TOT_W + 1)'(s_ff);
   assign over_cap   = sum_ext > {1'b0, cap_ff};
   assign over_max   = sum_ext > spmq_pkg::TOTAL_MAX;
   assign ec_is_ch   = blk_rd_ff.chan == ch_ff;

   // queue record after unlinking the block under release
   always_comb begin
      rel_rec.head  = (cprev_rd_ff == spmq_pkg::NIL) ? cnext_rd_ff : ch_rd_ff.head;
      rel_rec.tail  = (cnext_rd_ff == spmq_pkg::NIL) ? cprev_rd_ff : ch_rd_ff.tail;
      rel_rec.count = (ch_rd_ff.count != '0) ? ch_rd_ff.count - 6'd1 : '0;
   end

   // queue record after linking the new block
   always_comb begin
      pl_rec.count = ch_rd_ff.count + 6'd1;
      if (act_ff == spmq_pkg::ACT_PUSH_HEAD) begin
         pl_rec.head = b_ff;
         pl_rec.tail = (ch_rd_ff.head == spmq_pkg::NIL) ? b_ff : ch_rd_ff.tail;
      end else begin
         pl_rec.head = (ch_rd_ff.tail == spmq_pkg::NIL) ? b_ff : ch_rd_ff.head;
         pl_rec.tail = b_ff;
      end
   end

   // memory requests per step
   always_comb begin
      tn_wr    = '0;
      tp_wr    = '0;
      cn_wr    = '0;
      cp_wr    = '0;
      blk_we   = 1'b0;
      ch_we    = 1'b0;
      ch_wdata = rel_rec;
      ch_waddr = ch_ff;
      ch_raddr = ch_ff;
      unique case (state_ff)
         S_IDLE: begin
            ch_raddr = req_tdata[3:0];
         end
         S_REL_LNK: begin
            ch_raddr = blk_rd_ff.chan;
            if (tp_rd != spmq_pkg::NIL) tn_wr = '{1'b1, tp_rd, tn_rd};
            if (tn_rd != spmq_pkg::NIL) tp_wr = '{1'b1, tn_rd, tp_rd};
            if (cprev_rd_ff != spmq_pkg::NIL) cn_wr = '{1'b1, cprev_rd_ff, cnext_rd_ff};
            if (cnext_rd_ff != spmq_pkg::NIL) cp_wr = '{1'b1, cnext_rd_ff, cprev_rd_ff};
         end
         S_REL_FIN: begin
            // block goes back on the free list
            tn_wr    = '{1'b1, b_ff, fhead_ff};
            tp_wr    = '{1'b1, b_ff, spmq_pkg::NIL};
            ch_we    = 1'b1;
            ch_wdata = rel_rec;
            ch_waddr = blk_rd_ff.chan;
         end
         S_PL_A: begin
            blk_we = 1'b1;
            if (act_ff == spmq_pkg::ACT_PUSH_HEAD) begin
               tp_wr = '{1'b1, b_ff, spmq_pkg::NIL};
               tn_wr = '{1'b1, b_ff, dhead_ff};
               cp_wr = '{1'b1, b_ff, spmq_pkg::NIL};
               cn_wr = '{1'b1, b_ff, ch_rd_ff.head};
            end else begin
               tn_wr = '{1'b1, b_ff, spmq_pkg::NIL};
               tp_wr = '{1'b1, b_ff, dtail_ff};
               cn_wr = '{1'b1, b_ff, spmq_pkg::NIL};
               cp_wr = '{1'b1, b_ff, ch_rd_ff.tail};
            end
         end
         S_PL_B: begin
            ch_we    = 1'b1;
            ch_wdata = pl_rec;
            if (act_ff == spmq_pkg::ACT_PUSH_HEAD) begin
               if (dhead_ff != spmq_pkg::NIL) tp_wr = '{1'b1, dhead_ff, b_ff};
               if (ch_rd_ff.head != spmq_pkg::NIL) cp_wr = '{1'b1, ch_rd_ff.head, b_ff};
            end else begin
               if (dtail_ff != spmq_pkg::NIL) tn_wr = '{1'b1, dtail_ff, b_ff};
               if (ch_rd_ff.tail != spmq_pkg::NIL) cn_wr = '{1'b1, ch_rd_ff.tail, b_ff};
            end
         end
         default: begin
         end
      endcase
   end

   spmq_lmem #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .RST_MODE   (spmq_pkg::LM_RST_CHAIN)
   ) u_tnext (
      .clock   (clock),
      .reset   (reset),
      .wr      (tn_wr),
      .rd_addr (b_ff),
      .rd_data (tn_rd)
   );

   spmq_lmem #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .RST_MODE   (spmq_pkg::LM_RST_NIL)
   ) u_tprev (
      .clock   (clock),
      .reset   (reset),
      .wr      (tp_wr),
      .rd_addr (b_ff),
      .rd_data (tp_rd)
   );

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[bi] <= '{h_ff, s_ff, ch_ff};
      end
      if (cn_wr.en) begin
         cnext_mem[cn_wr.addr[BW-1:0]] <= cn_wr.data;
      end
      if (cp_wr.en) begin
         cprev_mem[cp_wr.addr[BW-1:0]] <= cp_wr.data;
      end
      if (ch_we) begin
         ch_mem[ch_wa_ext[CW-1:0]] <= ch_wdata;
      end
      blk_rd_ff   <= blk_mem[bi];
      cnext_rd_ff <= cnext_mem[bi];
      cprev_rd_ff <= cprev_mem[bi];
      ch_rd_ff    <= chv_ff[ch_ra_ext[CW-1:0]] ? ch_mem[ch_ra_ext[CW-1:0]]
                   : spmq_pkg::chan_rec_type'{spmq_pkg::NIL, spmq_pkg::NIL, 6'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chv_ff <= '0;
      end else if (ch_we) begin
         chv_ff[ch_wa_ext[CW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 21'd32768;
         total_ff     <= '0;
         dhead_ff     <= spmq_pkg::NIL;
         dtail_ff     <= spmq_pkg::NIL;
         fhead_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  act_ff  <= req_tuser;
                  ch_ff   <= req_tdata[3:0];
                  h_ff    <= req_tdata[19:4];
                  s_ff    <= req_tdata[39:20];
                  drop_ff <= req_tdata[40];
                  if (req_oor) begin
                     rsp_ff       <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b0, '0, '0,
                                            req_tdata[3:0], '0, total_ff, 1'b1);
                     rsp_valid_ff <= 1'b1;
                     ret_ff       <= S_IDLE;
                     state_ff     <= S_OUT;
                  end else begin
                     state_ff <= S_LOAD;
                  end
               end
            end
            S_LOAD: begin
               cnt_ff   <= ch_rd_ff.count;
               chead_ff <= ch_rd_ff.head;
               case (act_ff)
                  spmq_pkg::ACT_PUSH_TAIL: begin
                     state_ff <= S_CHECK;
                  end
                  spmq_pkg::ACT_PUSH_HEAD: begin
                     if (fhead_ff != spmq_pkg::NIL && !over_max) begin
                        b_ff     <= fhead_ff;
                        state_ff <= S_PL_RD;
                     end else begin
                        rsp_ff       <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b0, '0, '0, ch_ff,
                                               ch_rd_ff.count, total_ff, 1'b1);
                        rsp_valid_ff <= 1'b1;
                        ret_ff       <= S_IDLE;
                        state_ff     <= S_OUT;
                     end
                  end
                  spmq_pkg::ACT_POP: begin
                     if (ch_rd_ff.head != spmq_pkg::NIL) begin
                        b_ff     <= ch_rd_ff.head;
                        state_ff <= S_REL_RD;
                     end else begin
                        rsp_ff       <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b0, '0, '0, ch_ff,
                                               ch_rd_ff.count, total_ff, 1'b1);
                        rsp_valid_ff <= 1'b1;
                        ret_ff       <= S_IDLE;
                        state_ff     <= S_OUT;
                     end
                  end
                  default: begin
                     state_ff <= S_CLR;
                  end
               endcase
            end
            S_CHECK: begin
               if (over_cap && (!drop_ff || dhead_ff == spmq_pkg::NIL)) begin
                  rsp_ff       <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b0, '0, '0, ch_ff,
                                         cnt_ff, total_ff, 1'b1);
                  rsp_valid_ff <= 1'b1;
                  ret_ff       <= S_IDLE;
                  state_ff     <= S_OUT;
               end else if (over_cap) begin
                  // evict the packet at the head of the pool-wide list, whichever channel it is on
                  b_ff     <= dhead_ff;
                  state_ff <= S_REL_RD;
               end else if (fhead_ff == spmq_pkg::NIL) begin
                  rsp_ff       <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b0, '0, '0, ch_ff,
                                         cnt_ff, total_ff, 1'b1);
                  rsp_valid_ff <= 1'b1;
                  ret_ff       <= S_IDLE;
                  state_ff     <= S_OUT;
               end else begin
                  b_ff     <= fhead_ff;
                  state_ff <= S_PL_RD;
               end
            end
            S_CLR: begin
               if (chead_ff == spmq_pkg::NIL) begin
                  rsp_ff       <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b1, '0, '0, ch_ff,
                                         '0, total_ff, 1'b1);
                  rsp_valid_ff <= 1'b1;
                  ret_ff       <= S_IDLE;
                  state_ff     <= S_OUT;
               end else begin
                  b_ff     <= chead_ff;
                  state_ff <= S_REL_RD;
               end
            end
            S_REL_RD: begin
               state_ff <= S_REL_LNK;
            end
            S_REL_LNK: begin
               if (tp_rd == spmq_pkg::NIL) dhead_ff <= tn_rd;
               if (tn_rd == spmq_pkg::NIL) dtail_ff <= tp_rd;
               total_ff <= (total_ff >= spmq_pkg::TOT_W'(blk_rd_ff.size))
                         ? total_ff - spmq_pkg::TOT_W'(blk_rd_ff.size) : '0;
               state_ff <= S_REL_FIN;
            end
            S_REL_FIN: begin
               fhead_ff     <= b_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
               if (ec_is_ch) begin
                  cnt_ff   <= rel_rec.count;
                  chead_ff <= rel_rec.head;
               end
               case (act_ff)
                  spmq_pkg::ACT_POP: begin
                     rsp_ff <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b1, blk_rd_ff.handle,
                                      blk_rd_ff.size, ch_ff, rel_rec.count, total_ff, 1'b1);
                     ret_ff <= S_IDLE;
                  end
                  spmq_pkg::ACT_CLEAR: begin
                     rsp_ff <= mk_rsp(spmq_pkg::KIND_RELEASED, 1'b1, blk_rd_ff.handle,
                                      blk_rd_ff.size, ch_ff, rel_rec.count, total_ff, 1'b0);
                     ret_ff <= S_CLR;
                  end
                  default: begin
                     rsp_ff <= mk_rsp(spmq_pkg::KIND_RELEASED, 1'b1, blk_rd_ff.handle,
                                      blk_rd_ff.size, blk_rd_ff.chan,
                                      ec_is_ch ? rel_rec.count : cnt_ff, total_ff, 1'b0);
                     ret_ff <= S_CHECK;
                  end
               endcase
            end
            S_PL_RD: begin
               state_ff <= S_PL_A;
            end
            S_PL_A: begin
               fhead_ff <= tn_rd;
               total_ff <= total_ff + spmq_pkg::TOT_W'(s_ff);
               state_ff <= S_PL_B;
            end
            S_PL_B: begin
               if (act_ff == spmq_pkg::ACT_PUSH_HEAD) begin
                  if (dhead_ff == spmq_pkg::NIL) dtail_ff <= b_ff;
                  dhead_ff <= b_ff;
               end else begin
                  if (dtail_ff == spmq_pkg::NIL) dhead_ff <= b_ff;
                  dtail_ff <= b_ff;
               end
               rsp_ff       <= mk_rsp(spmq_pkg::KIND_STATUS, 1'b1, '0, '0, ch_ff,
                                      pl_rec.count, total_ff, 1'b1);
               rsp_valid_ff <= 1'b1;
               ret_ff       <= S_IDLE;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ret_ff;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.total, rsp_ff.count, rsp_ff.chan, rsp_ff.size,
                        rsp_ff.handle, rsp_ff.ok};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

   `SPMQ_ASSERT_NOW(a_idle_no_rsp, clock, reset, req_tready, !rsp_tvalid)
   `SPMQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `SPMQ_ASSERT_NEXT(a_idle_after_last, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tlast, req_tready)

endmodule
`default_nettype wire
